### rtl/core/brms_pkg.sv
// brms_pkg: shared widths, limits, job record and back-end state codes for the
// block RMS meter. No dependencies; used by every module under rtl/core.
package brms_pkg;

   // Block limits
   localparam int BLOCK_MAX = 4096;
   localparam int CNT_W     = 13;   // holds 0..BLOCK_MAX

   // Sample path
   localparam int SAMPLE_W  = 32;
   localparam int HALF_W    = 16;
   localparam int MAG_W     = 32;   // |sample| up to 2^31
   localparam int SQ_SHIFT  = 16;   // 32-bit mode squares drop 16 bits
   localparam int PROD_W    = 2 * MAG_W;
   localparam int SQ_W      = PROD_W - SQ_SHIFT;
   localparam int SUM_W     = 59;   // sum of squares never exceeds 2^58

   // Divide and root
   localparam int DREM_W    = CNT_W + 1;
   localparam int ROOT_W    = 30;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SREM_W    = ROOT_W + 3;
   localparam int STEP_W    = 6;
   localparam int WIDE_W    = ROOT_W + 8;  // root << 8 before saturation
   localparam int LEVEL_SHIFT = 8;

   // Result
   localparam int LEVEL_W   = 31;
   localparam logic [LEVEL_W-1:0] SAT16 = 31'd32767;
   localparam logic [LEVEL_W-1:0] SAT32 = 31'h7FFF_FFFF;

   // Block queue
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;

   // Sample width mode codes
   localparam logic MODE_16 = 1'b0;
   localparam logic MODE_32 = 1'b1;

   // One finished block, handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic             overflow;
      logic             mode;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_ROOT,
      BK_FIN
   } back_state_type;

endpackage

### rtl/core/brms_front.sv
// brms_front: sample intake, width mode register, squaring pipe and accumulator.
// Pushes one brms_pkg::job_type per finished block into the block queue.
// Depends on brms_pkg.
module brms_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [brms_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                           req_block_end,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   input  logic [brms_pkg::QCNT_W-1:0]    q_count,
   output logic                           push_valid,
   output brms_pkg::job_type              push_job
);

   logic                          mode_ff, mode_in;
   logic [brms_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          ovf_ff, ovf_in;

   // stage 1: magnitude
   logic                          s1_valid_ff, s1_end_ff, s1_keep_ff, s1_mode_ff, s1_ovf_ff;
   logic [brms_pkg::MAG_W-1:0]    s1_mag_ff, s1_mag_in;
   logic [brms_pkg::CNT_W-1:0]    s1_cnt_ff;

   // stage 2: scaled square
   logic                          s2_valid_ff, s2_end_ff, s2_mode_ff, s2_ovf_ff;
   logic [brms_pkg::SQ_W-1:0]     s2_sq_ff, s2_sq_in;
   logic [brms_pkg::CNT_W-1:0]    s2_cnt_ff;

   logic [brms_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_total;

   logic                          accept, keep;
   logic [brms_pkg::CNT_W-1:0]    cnt_next;
   logic                          ovf_next;
   logic [brms_pkg::HALF_W:0]     mag16;
   logic [brms_pkg::SAMPLE_W:0]   mag32;
   logic [brms_pkg::PROD_W-1:0]   product;
   logic [brms_pkg::QCNT_W:0]     pending;

   // Block-end beats already in the pipe hold a queue slot in advance
   assign pending = {1'b0, q_count}
                  + (brms_pkg::QCNT_W+1)'(s1_valid_ff & s1_end_ff)
                  + (brms_pkg::QCNT_W+1)'(s2_valid_ff & s2_end_ff);
   assign req_ready = pending < (brms_pkg::QCNT_W+1)'(brms_pkg::QDEPTH);
   assign accept    = req_valid & req_ready;

   assign keep     = cnt_ff < brms_pkg::CNT_W'(brms_pkg::BLOCK_MAX);
   assign cnt_next = keep ? cnt_ff + 1'b1 : cnt_ff;
   assign ovf_next = ovf_ff | ~keep;

   // two's complement magnitude of the active sample width
   always_comb begin
      mag16 = req_sample_value[brms_pkg::HALF_W-1]
            ? (17'h1_0000 - {1'b0, req_sample_value[brms_pkg::HALF_W-1:0]})
            : {1'b0, req_sample_value[brms_pkg::HALF_W-1:0]};
      mag32 = req_sample_value[brms_pkg::SAMPLE_W-1]
            ? (33'h1_0000_0000 - {1'b0, req_sample_value})
            : {1'b0, req_sample_value};
      s1_mag_in = (mode_ff == brms_pkg::MODE_32) ? mag32[brms_pkg::MAG_W-1:0]
                                                 : brms_pkg::MAG_W'(mag16);
   end

   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         cnt_in = req_block_end ? '0 : cnt_next;
         ovf_in = req_block_end ? 1'b0 : ovf_next;
      end
   end

   assign product = s1_mag_ff * s1_mag_ff;
   always_comb begin
      if (!s1_keep_ff) begin
         s2_sq_in = '0;
      end else if (s1_mode_ff == brms_pkg::MODE_32) begin
         s2_sq_in = product[brms_pkg::PROD_W-1:brms_pkg::SQ_SHIFT];
      end else begin
         s2_sq_in = product[brms_pkg::SQ_W-1:0];
      end
   end

   assign sum_total  = sum_ff + brms_pkg::SUM_W'(s2_sq_ff);
   assign push_valid = s2_valid_ff & s2_end_ff;
   assign push_job   = '{sum: sum_total, count: s2_cnt_ff, overflow: s2_ovf_ff,
                         mode: s2_mode_ff};

   always_comb begin
      sum_in = sum_ff;
      if (s2_valid_ff) begin
         sum_in = s2_end_ff ? '0 : sum_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= brms_pkg::MODE_16;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff  <= s1_mag_in;
         s1_end_ff  <= req_block_end;
         s1_keep_ff <= keep;
         s1_mode_ff <= mode_ff;
         s1_cnt_ff  <= cnt_next;
         s1_ovf_ff  <= ovf_next;
      end
      if (s1_valid_ff) begin
         s2_sq_ff   <= s2_sq_in;
         s2_end_ff  <= s1_end_ff;
         s2_mode_ff <= s1_mode_ff;
         s2_cnt_ff  <= s1_cnt_ff;
         s2_ovf_ff  <= s1_ovf_ff;
      end
   end

endmodule

### rtl/core/brms_queue.sv
// brms_queue: small FIFO of finished-block jobs between front and back.
// Depends on brms_pkg.
module brms_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  brms_pkg::job_type           push_job,
   input  logic                        pop,
   output brms_pkg::job_type           head,
   output logic                        empty,
   output logic [brms_pkg::QCNT_W-1:0] count
);

   brms_pkg::job_type              entry_ff [brms_pkg::QDEPTH];
   logic [brms_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [brms_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [brms_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + brms_pkg::QCNT_W'(push_valid) - brms_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/brms_back.sv
// brms_back: per-block mean (radix-2 restoring divide), integer square root
// (two bits per step), scaling/saturation and the result register.
// Depends on brms_pkg.
module brms_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  brms_pkg::job_type              q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [brms_pkg::LEVEL_W-1:0]   rsp_rms_level,
   output logic                           rsp_block_overflow
);

   brms_pkg::back_state_type      state_ff, state_in;
   logic [brms_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [brms_pkg::CNT_W-1:0]    den_ff, den_in;
   logic [brms_pkg::DREM_W-1:0]   drem_ff, drem_in;
   logic [brms_pkg::SUM_W-1:0]    quo_ff, quo_in;
   logic [brms_pkg::RAD_W-1:0]    rad_ff, rad_in;
   logic [brms_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [brms_pkg::SREM_W-1:0]   srem_ff, srem_in;
   logic                          mode_ff, mode_in;
   logic                          ovf_ff, ovf_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [brms_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic [brms_pkg::DREM_W-1:0]   drem_sh;
   logic                          div_ge;
   logic [brms_pkg::SREM_W-1:0]   srem_sh, trial;
   logic                          root_ge;
   logic [brms_pkg::WIDE_W-1:0]   root_wide;
   logic [brms_pkg::LEVEL_W-1:0]  level_calc;
   logic                          out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rms_level      = level_ff;
   assign rsp_block_overflow = rsp_ovf_ff;
   assign out_free           = ~rsp_valid_ff | rsp_ready;

   // one quotient bit per step
   assign drem_sh = {drem_ff[brms_pkg::DREM_W-2:0], quo_ff[brms_pkg::SUM_W-1]};
   assign div_ge  = drem_sh >= {1'b0, den_ff};

   // one root bit per step
   assign srem_sh = {srem_ff[brms_pkg::SREM_W-3:0],
                     rad_ff[brms_pkg::RAD_W-1:brms_pkg::RAD_W-2]};
   assign trial   = brms_pkg::SREM_W'({root_ff, 2'b01});
   assign root_ge = srem_sh >= trial;

   always_comb begin
      root_wide = brms_pkg::WIDE_W'(root_ff) << brms_pkg::LEVEL_SHIFT;
      if (mode_ff == brms_pkg::MODE_32) begin
         level_calc = (root_wide > brms_pkg::WIDE_W'(brms_pkg::SAT32))
                    ? brms_pkg::SAT32 : root_wide[brms_pkg::LEVEL_W-1:0];
      end else begin
         level_calc = (brms_pkg::LEVEL_W'(root_ff) > brms_pkg::SAT16)
                    ? brms_pkg::SAT16 : brms_pkg::LEVEL_W'(root_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      den_in       = den_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      mode_in      = mode_ff;
      ovf_in       = ovf_ff;
      level_in     = level_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      q_pop        = 1'b0;
      unique case (state_ff)
         brms_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               den_in   = q_head.count;
               quo_in   = q_head.sum;
               drem_in  = '0;
               mode_in  = q_head.mode;
               ovf_in   = q_head.overflow;
               step_in  = '0;
               state_in = brms_pkg::BK_DIV;
            end
         end
         brms_pkg::BK_DIV: begin
            drem_in = div_ge ? drem_sh - {1'b0, den_ff} : drem_sh;
            quo_in  = {quo_ff[brms_pkg::SUM_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == brms_pkg::STEP_W'(brms_pkg::SUM_W - 1)) begin
               // empty count gives a zero mean
               rad_in   = (den_ff == '0) ? '0 : brms_pkg::RAD_W'(quo_in);
               root_in  = '0;
               srem_in  = '0;
               step_in  = '0;
               state_in = brms_pkg::BK_ROOT;
            end
         end
         brms_pkg::BK_ROOT: begin
            srem_in = root_ge ? srem_sh - trial : srem_sh;
            root_in = {root_ff[brms_pkg::ROOT_W-2:0], root_ge};
            rad_in  = rad_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == brms_pkg::STEP_W'(brms_pkg::ROOT_W - 1)) begin
               state_in = brms_pkg::BK_FIN;
            end
         end
         brms_pkg::BK_FIN: begin
            if (out_free) begin
               level_in     = level_calc;
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = brms_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = brms_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brms_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      den_ff     <= den_in;
      drem_ff    <= drem_in;
      quo_ff     <= quo_in;
      rad_ff     <= rad_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      mode_ff    <= mode_in;
      ovf_ff     <= ovf_in;
      level_ff   <= level_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

endmodule

### rtl/core/block_rms_meter.sv
// block_rms_meter: top level of the block RMS meter.
// Instantiates brms_front, brms_queue and brms_back; depends on brms_pkg.
//
//   channel  | handshake              | beat contents
//   ---------+------------------------+-----------------------------------------
//   req      | req_valid / req_ready  | req_sample_value[31:0], req_block_end
//   rsp      | rsp_valid / rsp_ready  | rsp_rms_level[30:0], rsp_block_overflow
//   csr      | csr_write_enable       | csr_write_data (sample width mode)
//
// Flow: the front takes one sample beat per cycle while req_ready is high; each
// beat is registered as a magnitude, then squared and summed. A block-end beat
// hands its sum, count, overflow flag and width mode to a four-entry job queue.
// The back serves one job at a time: 59 restoring-divide steps for the mean,
// 30 two-bit square root steps and the result load, so it bounds the block rate.
// Stalls: req_ready drops only while the queue and the block ends still in the
// squaring pipe fill all four slots. A held result stops the front only via the queue.
// Reset (synchronous) clears the mode to 16-bit, the sum, count and overflow
// flag, the queue, and the result valid; no clearing pass is needed.
module block_rms_meter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [brms_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                           req_block_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [brms_pkg::LEVEL_W-1:0]   rsp_rms_level,
   output logic                           rsp_block_overflow,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data
);

   logic                           push_valid;
   brms_pkg::job_type              push_job;
   logic                           q_pop;
   brms_pkg::job_type              q_head;
   logic                           q_empty;
   logic [brms_pkg::QCNT_W-1:0]    q_count;

   // front: width mode, magnitude, square, accumulate, block close-out
   brms_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_block_end    (req_block_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_count          (q_count),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   // finished blocks waiting for the divider
   brms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .count      (q_count)
   );

   // back: mean, root, scale and saturate, result register
   brms_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rms_level      (rsp_rms_level),
      .rsp_block_overflow (rsp_block_overflow)
   );

endmodule
